// File: rtl/imf_pkg.sv
// Shared constants, codes and types of the indexed 3x3 mode filter.
`timescale 1ns / 1ps
package imf_pkg;
   localparam int MAX_WIDTH_DEF = 512;
   localparam int MAX_HEIGHT    = 1024;
   localparam int NUM_INDEX     = 16;
   localparam int PIX_W         = 8;
   localparam int IDX_W         = 4;
   localparam int CNT_W         = 4;
   localparam int WIN_N         = 9;
   localparam int FW_W          = 10;
   localparam int FH_W          = 11;
   localparam int ROW_W         = 10;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [FW_W-1:0] WIDTH_RESET  = 10'd320;
   localparam logic [FH_W-1:0] HEIGHT_RESET = 11'd200;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_idx_type;

   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

   typedef struct packed {
      logic is_pix;
      logic wbank;
      logic tail_en;
      logic tail_bank;
      logic tail_end;
      logic own_en;
      logic own_mode;
   } cmd_flags_type;
endpackage

// File: rtl/imf_queue.sv
// Small command queue between the front and back parts of the filter.
`timescale 1ns / 1ps
module imf_queue #(
   parameter int DW    = 8,
   parameter int DEPTH = imf_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   input  logic          pop,
   output logic [DW-1:0] head_data,
   output logic          full,
   output logic          empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DW-1:0]    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: rtl/imf_front.sv
// Front part: raster position tracking and classification of each beat.
`timescale 1ns / 1ps
module imf_front #(
   parameter int MAX_WIDTH = imf_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
   input  logic [imf_pkg::FH_W-1:0]        eff_h,
   input  logic                            req_valid,
   input  logic                            req_func,
   input  logic [imf_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                            q_full,
   output logic                            req_stall,
   output logic                            push,
   output imf_pkg::cmd_flags_type          flags,
   output logic [imf_pkg::PIX_W-1:0]       px,
   output logic [$clog2(MAX_WIDTH)-1:0]    addr,
   output logic [$clog2(MAX_WIDTH)-1:0]    taddr
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = $clog2(MAX_WIDTH + 2);

   logic [AW-1:0]                 col_ff, col_in;
   logic [imf_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [PW-1:0]                 pend_ff, pend_in;
   logic                          par_ff, par_in;
   logic                          tbank_ff, tbank_in;
   logic                          accept;
   logic                          is_pix;
   logic                          tail_en;
   logic                          first_tail;
   logic                          col_last;
   logic                          row_last;
   logic                          past_first;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign is_pix     = (req_func == imf_pkg::FUNC_PIXEL);
   assign tail_en    = (pend_ff != '0);
   assign first_tail = (pend_ff == PW'(eff_w) + PW'(1));
   assign col_last   = (WW'(col_ff) + WW'(1) == eff_w);
   assign row_last   = (imf_pkg::FH_W'(row_ff) + imf_pkg::FH_W'(1) == eff_h);
   assign past_first = (row_ff >= imf_pkg::ROW_W'(2)) ||
                       ((row_ff == imf_pkg::ROW_W'(1)) && (col_ff != '0));

   assign push  = accept && (is_pix || tail_en);
   assign px    = req_pixel_in;
   assign addr  = col_ff;
   assign taddr = first_tail ? AW'(eff_w - WW'(1)) : AW'(PW'(eff_w) - pend_ff);

   always_comb begin
      flags.is_pix    = is_pix;
      flags.wbank     = par_ff;
      flags.tail_en   = tail_en;
      flags.tail_bank = first_tail ? !tbank_ff : tbank_ff;
      flags.tail_end  = (pend_ff == PW'(1));
      flags.own_en    = is_pix && !tail_en && past_first;
      flags.own_mode  = (col_ff != '0) && (row_ff != imf_pkg::ROW_W'(1)) &&
                        (col_ff != AW'(1));
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      par_in   = par_ff;
      tbank_in = tbank_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (accept) begin
         if (tail_en) begin
            pend_in = pend_ff - PW'(1);
         end
         if (is_pix) begin
            if (col_last) begin
               col_in = '0;
               par_in = !par_ff;
               if (row_last) begin
                  row_in   = '0;
                  pend_in  = PW'(eff_w) + PW'(1);
                  tbank_in = par_ff;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
         par_ff   <= 1'b0;
         tbank_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         par_ff   <= par_in;
         tbank_ff <= tbank_in;
      end
   end
endmodule

// File: rtl/imf_back.sv
// Back part: line stores, 3x3 window and the mode vote pipeline.
`timescale 1ns / 1ps
module imf_back #(
   parameter int MAX_WIDTH = imf_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  imf_pkg::cmd_flags_type        flags,
   input  logic [imf_pkg::PIX_W-1:0]     px,
   input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]  taddr,
   output logic                          pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [imf_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_frame_end,
   output logic                          rsp_replaced
);
   localparam int P  = imf_pkg::PIX_W;
   localparam int NI = imf_pkg::NUM_INDEX;
   localparam int CW = imf_pkg::CNT_W;
   localparam int IW = imf_pkg::IDX_W;

   logic [P-1:0]  bank0_ff [MAX_WIDTH];
   logic [P-1:0]  bank1_ff [MAX_WIDTH];
   logic [P-1:0]  rd0_a_ff, rd1_a_ff, rd0_t_ff, rd1_t_ff;

   logic                    s1_valid_ff;
   imf_pkg::cmd_flags_type  s1_flags_ff;
   logic [P-1:0]            s1_px_ff;
   logic [P-1:0]            up_rd, mid_rd, tail_rd;

   logic [P-1:0]            win_ff [imf_pkg::WIN_N];
   logic                    s2_valid_ff, s2_mode_ff, s2_end_ff;
   logic [P-1:0]            s2_val_ff;

   logic                    s3_valid_ff, s3_mode_ff, s3_end_ff;
   logic [P-1:0]            s3_val_ff;
   logic [CW-1:0]           s3_cnt_ff [NI];
   logic [CW-1:0]           cnt_in [NI];

   logic [CW-1:0]           m8 [8];
   logic [CW-1:0]           m4 [4];
   logic [CW-1:0]           m2 [2];
   logic [CW-1:0]           cnt_max;
   logic [CW-1:0]           cnt_centre;
   logic [IW-1:0]           best_idx;
   logic                    do_replace;
   logic [P-1:0]            out_val;

   logic                    adv;
   logic                    rsp_valid_ff;
   logic [P-1:0]            rsp_pixel_ff;
   logic                    rsp_end_ff, rsp_rep_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !q_empty;

   always_ff @(posedge clock) begin
      if (pop) begin
         if (flags.is_pix && !flags.wbank) begin
            bank0_ff[addr] <= px;
         end
         rd0_a_ff <= bank0_ff[addr];
         rd0_t_ff <= bank0_ff[taddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (flags.is_pix && flags.wbank) begin
            bank1_ff[addr] <= px;
         end
         rd1_a_ff <= bank1_ff[addr];
         rd1_t_ff <= bank1_ff[taddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_flags_ff <= flags;
         s1_px_ff    <= px;
      end
   end

   assign up_rd   = s1_flags_ff.wbank ? rd1_a_ff : rd0_a_ff;
   assign mid_rd  = s1_flags_ff.wbank ? rd0_a_ff : rd1_a_ff;
   assign tail_rd = s1_flags_ff.tail_bank ? rd1_t_ff : rd0_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && (s1_flags_ff.tail_en || s1_flags_ff.own_en);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         s2_val_ff  <= s1_flags_ff.tail_en ? tail_rd : win_ff[5];
         s2_mode_ff <= s1_flags_ff.own_en && s1_flags_ff.own_mode;
         s2_end_ff  <= s1_flags_ff.tail_en && s1_flags_ff.tail_end;
         if (s1_flags_ff.is_pix) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= up_rd;
            win_ff[3] <= win_ff[4];
            win_ff[4] <= win_ff[5];
            win_ff[5] <= mid_rd;
            win_ff[6] <= win_ff[7];
            win_ff[7] <= win_ff[8];
            win_ff[8] <= s1_px_ff;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NI; i++) begin
         cnt_in[i] = '0;
         for (int j = 0; j < imf_pkg::WIN_N; j++) begin
            cnt_in[i] = cnt_in[i] + CW'(win_ff[j][IW-1:0] == IW'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         s3_val_ff  <= s2_val_ff;
         s3_mode_ff <= s2_mode_ff;
         s3_end_ff  <= s2_end_ff;
         for (int i = 0; i < NI; i++) begin
            s3_cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         m8[i] = (s3_cnt_ff[2*i] > s3_cnt_ff[2*i+1]) ? s3_cnt_ff[2*i] : s3_cnt_ff[2*i+1];
      end
      for (int i = 0; i < 4; i++) begin
         m4[i] = (m8[2*i] > m8[2*i+1]) ? m8[2*i] : m8[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         m2[i] = (m4[2*i] > m4[2*i+1]) ? m4[2*i] : m4[2*i+1];
      end
      cnt_max    = (m2[0] > m2[1]) ? m2[0] : m2[1];
      cnt_centre = s3_cnt_ff[s3_val_ff[IW-1:0]];
      best_idx   = '0;
      for (int i = NI - 1; i >= 0; i--) begin
         if (s3_cnt_ff[i] == cnt_max) begin
            best_idx = IW'(i);
         end
      end
      do_replace = s3_mode_ff && (cnt_max > cnt_centre);
      out_val    = do_replace ? {s3_val_ff[P-1:IW], best_idx} : s3_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_valid_ff) begin
         rsp_pixel_ff <= out_val;
         rsp_end_ff   <= s3_end_ff;
         rsp_rep_ff   <= do_replace;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_replaced  = rsp_rep_ff;
endmodule

// File: rtl/indexed_mode_filter_3x3.sv
// Top level of the streaming 3x3 mode filter on indexed pixels.
//
// Pixels enter on the req_ channel in raster order, one byte a beat
// (brightness high nibble, colour index low nibble); req_func high marks a
// flush beat without pixel. Each pixel leaves on the rsp_ channel width+1
// positions later with its index replaced by the window mode where that
// mode beats the centre; the last width+1 pixels of a frame leave on flush
// beats or on the next frame's pixels, the very last with rsp_frame_end.
// Frame size is set through the csr_ port (width at 0x0, height at 0x4);
// any write restarts the frame and drops a pending tail.
// Beats are taken one per cycle unless req_stall is high; a result passes
// through the queue, line store read, window, vote count and output stages.
// The line stores each take a write and two reads per cycle.
// A four-entry queue lets req_ keep accepting while rsp_stall holds the
// back pipeline; req_stall rises only when that queue is full.
// Reset empties the pipeline and returns size to 320 x 200; line store
// contents are left as they are and are never shown before being written.
`timescale 1ns / 1ps
module indexed_mode_filter_3x3 #(
   parameter int MAX_WIDTH = imf_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [imf_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [imf_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_frame_end,
   output logic                          rsp_replaced,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [imf_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [imf_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [imf_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int QW = $bits(imf_pkg::cmd_flags_type) + imf_pkg::PIX_W + 2 * AW;

   logic [imf_pkg::FW_W-1:0]  width_ff, width_in;
   logic [imf_pkg::FH_W-1:0]  height_ff, height_in;
   logic [WW-1:0]             eff_w;
   logic [imf_pkg::FH_W-1:0]  eff_h;
   logic                      csr_wr;
   imf_pkg::reg_idx_type      csr_idx;

   logic                      q_push, q_pop, q_full, q_empty;
   imf_pkg::cmd_flags_type    f_flags, b_flags;
   logic [imf_pkg::PIX_W-1:0] f_px, b_px;
   logic [AW-1:0]             f_addr, f_taddr, b_addr, b_taddr;
   logic [QW-1:0]             q_in, q_out;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = imf_pkg::reg_idx_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            imf_pkg::REG_WIDTH:  width_in  = csr_pwdata[imf_pkg::FW_W-1:0];
            imf_pkg::REG_HEIGHT: height_in = csr_pwdata[imf_pkg::FH_W-1:0];
            default:             width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= imf_pkg::WIDTH_RESET;
         height_ff <= imf_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      if (32'(width_ff) < 32'd3) begin
         eff_w = WW'(3);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff < imf_pkg::FH_W'(3)) begin
         eff_h = imf_pkg::FH_W'(3);
      end else if (height_ff > imf_pkg::FH_W'(imf_pkg::MAX_HEIGHT)) begin
         eff_h = imf_pkg::FH_W'(imf_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   always_comb begin
      unique case (csr_idx)
         imf_pkg::REG_WIDTH:  csr_prdata = imf_pkg::CSR_DW'(width_ff);
         imf_pkg::REG_HEIGHT: csr_prdata = imf_pkg::CSR_DW'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   imf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_wr),
      .eff_w        (eff_w),
      .eff_h        (eff_h),
      .req_valid    (req_valid),
      .req_func     (req_func),
      .req_pixel_in (req_pixel_in),
      .q_full       (q_full),
      .req_stall    (req_stall),
      .push         (q_push),
      .flags        (f_flags),
      .px           (f_px),
      .addr         (f_addr),
      .taddr        (f_taddr)
   );

   assign q_in = {f_flags, f_px, f_addr, f_taddr};

   imf_queue #(.DW(QW), .DEPTH(imf_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head_data (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {b_flags, b_px, b_addr, b_taddr} = q_out;

   imf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .flags         (b_flags),
      .px            (b_px),
      .addr          (b_addr),
      .taddr         (b_taddr),
      .pop           (q_pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .rsp_replaced  (rsp_replaced)
   );

   a_tail_not_replaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> !rsp_replaced)
      else $error("tail pixel marked as replaced");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");
endmodule
